### rtl/core/gmc_pkg.sv
// Package: sizes, types, codes and helper functions for the grid minimum counter.
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 4096;
  localparam int VALUE_BITS = 4;

  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int COLS_W      = $clog2(MAX_COLS + 1);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
  localparam int LEN_W       = 8;
  localparam int RCNT_W      = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int COUNT_W     = 20;
  localparam int SUM_W       = 24;
  localparam int INC_W       = VALUE_BITS + 2;

  localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = LEN_W'(100);
  localparam logic [RCNT_W-1:0] ROW_COUNT_RESET  = RCNT_W'(100);

  typedef logic [VALUE_BITS-1:0] height_t;
  typedef logic [COL_W-1:0]      col_idx_t;
  typedef logic [COLS_W-1:0]     cols_t;
  typedef logic [ROW_W-1:0]      row_idx_t;
  typedef logic [ROWS_W-1:0]     rows_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [INC_W-1:0]      inc_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_ROW_COUNT  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ST_RUN,
    ST_SWEEP
  } state_t;

  // one line buffer entry: row r-2 above row r-1
  typedef struct packed {
    height_t upper;
    height_t middle;
  } line_word_t;

  // one window column: rows r-2, r-1, r
  typedef struct packed {
    height_t top;
    height_t mid;
    height_t bot;
  } column_t;

  // judge controls; A is centered on the middle cell, B on the newest column
  typedef struct packed {
    logic a_en;
    logic a_top;
    logic a_bot;
    logic a_left;
    logic a_right;
    logic b_en;
    logic b_top;
    logic b_left;
    logic last_step;
  } judge_ctrl_t;

  function automatic logic is_local_min(column_t lc, column_t cc, column_t rc,
                                        logic top, logic bot, logic left, logic right);
    height_t ctr;
    logic    ok;
    ctr = cc.mid;
    ok  = 1'b1;
    if (top && (cc.top < ctr)) ok = 1'b0;
    if (bot && (cc.bot < ctr)) ok = 1'b0;
    if (left) begin
      if (top && (lc.top < ctr)) ok = 1'b0;
      if (lc.mid < ctr) ok = 1'b0;
      if (bot && (lc.bot < ctr)) ok = 1'b0;
    end
    if (right) begin
      if (top && (rc.top < ctr)) ok = 1'b0;
      if (rc.mid < ctr) ok = 1'b0;
      if (bot && (rc.bot < ctr)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic count_t count_add(count_t a, logic [1:0] inc);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W + 1)'(inc);
    return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
  endfunction

  function automatic sum_t sum_add(sum_t a, inc_t inc);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(inc);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/gmc_in_if.sv
// Interface: input channel carrying one cell height per beat.
`timescale 1ns / 1ps

interface gmc_in_if;
  logic              valid;
  logic              ready;
  gmc_pkg::height_t  cell_height;

  modport source (output valid, output cell_height, input ready);
  modport sink   (input valid, input cell_height, output ready);
endinterface

### rtl/core/gmc_out_if.sv
// Interface: result channel carrying the minima count and risk sum.
`timescale 1ns / 1ps

interface gmc_out_if;
  logic             valid;
  logic             ready;
  gmc_pkg::count_t  minima_count;
  gmc_pkg::sum_t    risk_sum;

  modport source (output valid, output minima_count, output risk_sum, input ready);
  modport sink   (input valid, input minima_count, input risk_sum, output ready);
endinterface

### rtl/core/gmc_line_mem.sv
// Line buffer memory: rows r-2 and r-1 per column, registered read.
`timescale 1ns / 1ps

module gmc_line_mem (
  input  logic                 clk,
  input  gmc_pkg::col_idx_t    rd_addr,
  output gmc_pkg::line_word_t  rd_data,
  input  logic                 wr_en,
  input  gmc_pkg::col_idx_t    wr_addr,
  input  gmc_pkg::line_word_t  wr_data
);

  gmc_pkg::line_word_t mem [gmc_pkg::MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/gmc_cell.sv
// Window cell: holds one three-row column and hands it to its left neighbor.
`timescale 1ns / 1ps

module gmc_cell (
  input  logic              clk,
  input  logic              en,
  input  gmc_pkg::column_t  col_in,
  output gmc_pkg::column_t  col_out
);

  gmc_pkg::column_t col_q;

  always_ff @(posedge clk) begin
    if (en) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

endmodule

### rtl/core/grid_local_minimum_count_sum.sv
// Top level: streamed 3x3 local minimum counter with line buffers and window cells.
`timescale 1ns / 1ps

// Cells of a grid arrive on the cells channel in raster order, one height per
// beat; row_length and row_count set the grid size through the write port
// (index 0 and 1). The user must write them only while the block is idle; the
// block itself does not enforce it. One beat per cycle is taken while a grid
// streams and cells.ready is high. The line buffer is read in the accept
// cycle, the column enters the window cells in the next cycle and the two
// judges plus the running totals work in the cycle after that. On the last
// cell of a grid the final row is swept out of the line buffer, one column per
// cycle over the row length clamped to 1..128; cells.ready stays low during
// the sweep, and the result then appears on the results channel.
// The result sits in an output register; the next grid streams in while it
// waits, and only that grid's last cell is held off until the result is taken.
// Reset (rst, synchronous) clears positions, totals and the output valid and
// restores both size registers to 100. Line buffer contents are not cleared.

module grid_local_minimum_count_sum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [gmc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [gmc_pkg::CFG_DATA_W-1:0]        cfg_data,
  gmc_in_if.sink                                cells,
  gmc_out_if.source                             results
);

  logic [gmc_pkg::LEN_W-1:0]  row_length;
  logic [gmc_pkg::RCNT_W-1:0] row_count;
  gmc_pkg::cols_t             cols_eff;
  gmc_pkg::rows_t             rows_eff;

  gmc_pkg::state_t   state;
  gmc_pkg::state_t   state_next;
  gmc_pkg::col_idx_t col_pos;
  gmc_pkg::row_idx_t row_pos;
  gmc_pkg::cols_t    sweep_k;
  logic              sweep_top;
  logic              result_busy;

  logic last_col;
  logic last_row;
  logic grid_end;
  logic cells_fire;

  // stage A (accept / line read)
  logic                  a_valid;
  logic                  a_write;
  gmc_pkg::col_idx_t     a_addr;
  gmc_pkg::height_t      a_v;
  gmc_pkg::judge_ctrl_t  a_ctrl;
  logic                  a_fwd;

  // stage B (line data, window shift)
  logic                  s1_valid;
  logic                  s1_write;
  gmc_pkg::col_idx_t     s1_addr;
  gmc_pkg::height_t      s1_v;
  gmc_pkg::judge_ctrl_t  s1_ctrl;
  logic                  s1_fwd;
  gmc_pkg::line_word_t   s1_fwd_word;
  gmc_pkg::line_word_t   rd_data;
  gmc_pkg::line_word_t   line;
  gmc_pkg::line_word_t   wr_word;
  gmc_pkg::column_t      new_col;

  // stage C (judge, accumulate)
  logic                  s2_valid;
  gmc_pkg::judge_ctrl_t  s2_ctrl;
  gmc_pkg::column_t      win [3];
  logic                  a_hit;
  logic                  b_hit;
  logic [1:0]            cnt_inc;
  gmc_pkg::inc_t         sum_inc;
  gmc_pkg::count_t       count_total;
  gmc_pkg::sum_t         sum_total;
  gmc_pkg::count_t       count_next;
  gmc_pkg::sum_t         sum_next;

  logic                  out_valid;
  gmc_pkg::count_t       out_count;
  gmc_pkg::sum_t         out_sum;

  // effective sizes, clamped to the supported range
  always_comb begin
    if (row_length == '0) begin
      cols_eff = gmc_pkg::COLS_W'(1);
    end else if (32'(row_length) > gmc_pkg::MAX_COLS) begin
      cols_eff = gmc_pkg::COLS_W'(gmc_pkg::MAX_COLS);
    end else begin
      cols_eff = gmc_pkg::COLS_W'(row_length);
    end
    if (row_count == '0) begin
      rows_eff = gmc_pkg::ROWS_W'(1);
    end else if (32'(row_count) > gmc_pkg::MAX_ROWS) begin
      rows_eff = gmc_pkg::ROWS_W'(gmc_pkg::MAX_ROWS);
    end else begin
      rows_eff = gmc_pkg::ROWS_W'(row_count);
    end
  end

  assign last_col = (gmc_pkg::COLS_W'(col_pos) + gmc_pkg::COLS_W'(1)) >= cols_eff;
  assign last_row = (gmc_pkg::ROWS_W'(row_pos) + gmc_pkg::ROWS_W'(1)) >= rows_eff;
  assign grid_end = last_col && last_row;
  assign cells_fire = cells.valid && cells.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gmc_pkg::ST_RUN: begin
        if (cells_fire && grid_end) state_next = gmc_pkg::ST_SWEEP;
      end
      gmc_pkg::ST_SWEEP: begin
        if (sweep_k == cols_eff) state_next = gmc_pkg::ST_RUN;
      end
    endcase
  end

  // outputs of the sequencer: ready and the stage A beat
  always_comb begin
    cells.ready = 1'b0;
    a_valid     = 1'b0;
    a_write     = 1'b0;
    a_addr      = col_pos;
    a_v         = cells.cell_height;
    a_ctrl      = '0;
    unique case (state)
      gmc_pkg::ST_RUN: begin
        cells.ready      = !(grid_end && result_busy);
        a_valid          = cells_fire;
        a_write          = 1'b1;
        a_addr           = col_pos;
        a_ctrl.a_en      = (row_pos != '0) && (col_pos != '0);
        a_ctrl.a_top     = row_pos >= gmc_pkg::ROW_W'(2);
        a_ctrl.a_bot     = 1'b1;
        a_ctrl.a_left    = col_pos >= gmc_pkg::COL_W'(2);
        a_ctrl.a_right   = 1'b1;
        a_ctrl.b_en      = last_col && (row_pos != '0);
        a_ctrl.b_top     = row_pos >= gmc_pkg::ROW_W'(2);
        a_ctrl.b_left    = col_pos != '0;
      end
      gmc_pkg::ST_SWEEP: begin
        a_valid          = 1'b1;
        a_write          = 1'b0;
        a_addr           = sweep_k[gmc_pkg::COL_W-1:0];
        a_v              = '0;
        a_ctrl.a_en      = sweep_k != '0;
        a_ctrl.a_top     = sweep_top;
        a_ctrl.a_bot     = 1'b0;
        a_ctrl.a_left    = sweep_k >= gmc_pkg::COLS_W'(2);
        a_ctrl.a_right   = sweep_k < cols_eff;
        a_ctrl.last_step = sweep_k == cols_eff;
      end
    endcase
  end

  // read of a column still being written in stage B
  assign a_fwd = s1_valid && s1_write && (s1_addr == a_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gmc_pkg::ST_RUN;
      col_pos     <= '0;
      row_pos     <= '0;
      sweep_k     <= '0;
      sweep_top   <= 1'b0;
      result_busy <= 1'b0;
      row_length  <= gmc_pkg::ROW_LENGTH_RESET;
      row_count   <= gmc_pkg::ROW_COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (gmc_pkg::cfg_index_t'(cfg_index))
          gmc_pkg::CFG_ROW_LENGTH: row_length <= cfg_data[gmc_pkg::LEN_W-1:0];
          gmc_pkg::CFG_ROW_COUNT:  row_count  <= cfg_data[gmc_pkg::RCNT_W-1:0];
        endcase
      end
      if (cells_fire) begin
        if (grid_end) begin
          col_pos     <= '0;
          row_pos     <= '0;
          sweep_k     <= '0;
          sweep_top   <= row_pos != '0;
          result_busy <= 1'b1;
        end else if (last_col) begin
          col_pos <= '0;
          row_pos <= row_pos + gmc_pkg::ROW_W'(1);
        end else begin
          col_pos <= col_pos + gmc_pkg::COL_W'(1);
        end
      end
      if (state == gmc_pkg::ST_SWEEP) begin
        sweep_k <= sweep_k + gmc_pkg::COLS_W'(1);
      end
      if (results.valid && results.ready) begin
        result_busy <= 1'b0;
      end
    end
  end

  gmc_line_mem u_line_mem (
    .clk     (clk),
    .rd_addr (a_addr),
    .rd_data (rd_data),
    .wr_en   (s1_valid && s1_write),
    .wr_addr (s1_addr),
    .wr_data (wr_word)
  );

  // stage A -> B
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= a_valid;
    end
    s1_write    <= a_write;
    s1_addr     <= a_addr;
    s1_v        <= a_v;
    s1_ctrl     <= a_ctrl;
    s1_fwd      <= a_fwd;
    s1_fwd_word <= wr_word;
  end

  always_comb begin
    line           = s1_fwd ? s1_fwd_word : rd_data;
    wr_word.upper  = line.middle;
    wr_word.middle = s1_v;
    new_col.top    = line.upper;
    new_col.mid    = line.middle;
    new_col.bot    = s1_v;
  end

  // window: win[2] newest column, win[0] oldest
  gmc_cell u_cell2 (.clk(clk), .en(s1_valid), .col_in(new_col), .col_out(win[2]));
  gmc_cell u_cell1 (.clk(clk), .en(s1_valid), .col_in(win[2]),  .col_out(win[1]));
  gmc_cell u_cell0 (.clk(clk), .en(s1_valid), .col_in(win[1]),  .col_out(win[0]));

  // stage B -> C
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctrl <= s1_ctrl;
  end

  always_comb begin
    a_hit = s2_ctrl.a_en && gmc_pkg::is_local_min(win[0], win[1], win[2], s2_ctrl.a_top,
                                                  s2_ctrl.a_bot, s2_ctrl.a_left,
                                                  s2_ctrl.a_right);
    b_hit = s2_ctrl.b_en && gmc_pkg::is_local_min(win[1], win[2], win[2], s2_ctrl.b_top,
                                                  1'b1, s2_ctrl.b_left, 1'b0);
    cnt_inc = {1'b0, a_hit} + {1'b0, b_hit};
    sum_inc = (a_hit ? gmc_pkg::INC_W'(win[1].mid) + gmc_pkg::INC_W'(1) : '0)
            + (b_hit ? gmc_pkg::INC_W'(win[2].mid) + gmc_pkg::INC_W'(1) : '0);
    count_next = gmc_pkg::count_add(count_total, cnt_inc);
    sum_next   = gmc_pkg::sum_add(sum_total, sum_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_total <= '0;
      sum_total   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s2_valid) begin
        if (s2_ctrl.last_step) begin
          count_total <= '0;
          sum_total   <= '0;
        end else begin
          count_total <= count_next;
          sum_total   <= sum_next;
        end
      end
      if (s2_valid && s2_ctrl.last_step) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s2_valid && s2_ctrl.last_step) begin
      out_count <= count_next;
      out_sum   <= sum_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.minima_count = out_count;
  assign results.risk_sum     = out_sum;

endmodule

### rtl/core/gmc_checker.sv
// Checker: port-level properties of the grid minimum counter, bound to the top.
`timescale 1ns / 1ps

module gmc_checker (
  input logic             clk,
  input logic             rst,
  input logic             cells_valid,
  input logic             cells_ready,
  input logic             results_valid,
  input logic             results_ready,
  input gmc_pkg::count_t  minima_count,
  input gmc_pkg::sum_t    risk_sum
);

  // a stalled result beat is held
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid)
    else $error("result beat dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !results_valid)
    else $error("result valid after reset");

  // every minimum adds at least one to the sum
  a_sum_covers_count: assert property (@(posedge clk) disable iff (rst)
    results_valid |-> (gmc_pkg::SUM_W'(minima_count) <= risk_sum))
    else $error("risk sum below minima count");

  // a new result needs a whole new grid and its sweep, so a taken result is never followed straight by another
  a_no_adjacent_results: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_ready |=> !results_valid)
    else $error("second result right after a taken one");

  // a result waiting unsent stays valid while cells are being taken
  a_input_quiet_check: assert property (@(posedge clk) disable iff (rst)
    cells_valid && cells_ready && results_valid && !results_ready |=> results_valid)
    else $error("pending result lost while input streamed");

endmodule

bind grid_local_minimum_count_sum gmc_checker u_gmc_checker (
  .clk           (clk),
  .rst           (rst),
  .cells_valid   (cells.valid),
  .cells_ready   (cells.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .minima_count  (results.minima_count),
  .risk_sum      (results.risk_sum)
);
